// File: hw/rtl/mctb_pkg.sv
// package for the multi-channel timer bank
// holds sizes, request codes, sequencer states and the step unit result type
// no dependencies
`timescale 1ns / 1ps

package mctb_pkg;

  localparam int NUM_TIMERS  = 8;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_ARM    = 2'd1,
    MODE_DISARM = 2'd2,
    MODE_POLL   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_POLL,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] remaining;
    logic                   hit;
    logic                   keep_en;
  } step_res_t;

endpackage

// File: hw/rtl/mctb_step_unit.sv
// shared countdown unit: decrement one channel, detect expiry, pick reload
// depends on mctb_pkg
`timescale 1ns / 1ps

module mctb_step_unit
  import mctb_pkg::*;
(
  input  logic [COUNT_WIDTH-1:0] remaining,
  input  logic [COUNT_WIDTH-1:0] reload_value,
  input  logic                   repeat_mode,
  output step_res_t              res
);

  logic [COUNT_WIDTH-1:0] dec;

  always_comb begin
    dec = remaining - COUNT_WIDTH'(1);
    res.hit = (dec == '0);
    // periodic channels reload, one-shot channels drop their enable
    res.remaining = (res.hit && repeat_mode) ? reload_value : dec;
    res.keep_en = !res.hit || repeat_mode;
  end

endmodule

// File: hw/rtl/multi_channel_timer_bank_top.sv
// top level of the multi-channel timer bank: channel store, sequencer, output register
// depends on mctb_pkg and mctb_step_unit
//
//  channel | direction | tdata                                   | tuser  | tlast
//  in_     | request   | timer_index, interval, periodic, notify | mode   | -
//  out_    | result    | expired_index                           | fired  | last
//
// arm and disarm complete in the accept cycle; in_tready is high again next cycle.
// a tick visits one channel per cycle through the shared decrementer, every channel in turn.
// a poll scans one channel per cycle, except while an output stall holds it;
// an empty poll places its single result once the output register is free.
// out_tready low holds the scan at a reportable channel until the output register frees.
// rst_n (synchronous) clears all channel flags; counts are don't-care while disabled.
`timescale 1ns / 1ps

module multi_channel_timer_bank_top
  import mctb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [2:0] timer_index, [34:3] interval, [35] periodic, [36] notify, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] expired_index, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] fired
  output logic                  out_tuser,
  output logic                  out_tlast
);

  logic [COUNT_WIDTH-1:0] rem_r    [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] reload_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  en_r, rep_r, hnd_r, exp_r;
  logic [NUM_TIMERS-1:0]  mask_r, mask_nxt;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt;
  logic [2:0]        oidx_r, oidx_nxt;
  logic              ofired_r, ofired_nxt;
  logic              olast_r, olast_nxt;

  logic [2:0]             in_idx;
  logic [COUNT_WIDTH-1:0] in_ivl;
  logic                   in_per, in_ntf, idx_ok, accept, last_ch, slot_free;
  logic [IDX_W-1:0]       wr_idx;
  mode_t                  in_mode;
  step_res_t              step;

  assign in_idx  = in_tdata[2:0];
  assign in_ivl  = COUNT_WIDTH'(in_tdata[34:3]);
  assign in_per  = in_tdata[35];
  assign in_ntf  = in_tdata[36];
  assign in_mode = mode_t'(in_tuser);
  assign idx_ok  = (32'(in_idx) < NUM_TIMERS);
  assign wr_idx  = IDX_W'(in_idx);

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign last_ch   = (cnt_r == IDX_W'(NUM_TIMERS - 1));
  assign slot_free = !ov_r || out_tready;

  mctb_step_unit u_step (
    .remaining    (rem_r[cnt_r]),
    .reload_value (reload_r[cnt_r]),
    .repeat_mode  (rep_r[cnt_r]),
    .res          (step)
  );

  // sequencer and output register
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    mask_nxt   = mask_r;
    ov_nxt     = ov_r && !out_tready;
    oidx_nxt   = oidx_r;
    ofired_nxt = ofired_r;
    olast_nxt  = olast_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          case (in_mode)
            MODE_TICK: state_nxt = ST_TICK;
            MODE_POLL: begin
              mask_nxt  = exp_r & hnd_r;
              state_nxt = ((exp_r & hnd_r) == '0) ? ST_EMPTY : ST_POLL;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TICK: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (last_ch) state_nxt = ST_IDLE;
      end
      ST_POLL: begin
        if (!mask_r[cnt_r] || slot_free) begin
          if (mask_r[cnt_r]) begin
            ov_nxt     = 1'b1;
            oidx_nxt   = 3'(cnt_r);
            ofired_nxt = 1'b1;
            // last when no reportable channel lies above this one
            olast_nxt  = (((mask_r >> cnt_r) >> 1) == '0);
          end
          cnt_nxt = cnt_r + IDX_W'(1);
          if (last_ch) state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          oidx_nxt   = '0;
          ofired_nxt = 1'b0;
          olast_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    mask_r   <= mask_nxt;
    oidx_r   <= oidx_nxt;
    ofired_r <= ofired_nxt;
    olast_r  <= olast_nxt;
  end

  // channel flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= '0;
      rep_r <= '0;
      hnd_r <= '0;
      exp_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_mode)
              MODE_ARM: begin
                if (idx_ok) begin
                  en_r[wr_idx]  <= 1'b1;
                  rep_r[wr_idx] <= in_per;
                  hnd_r[wr_idx] <= in_ntf;
                  exp_r[wr_idx] <= 1'b0;
                end
              end
              MODE_DISARM: begin
                if (idx_ok) begin
                  en_r[wr_idx]  <= 1'b0;
                  rep_r[wr_idx] <= 1'b0;
                  hnd_r[wr_idx] <= 1'b0;
                  exp_r[wr_idx] <= 1'b0;
                end
              end
              MODE_POLL: exp_r <= '0;
              default: ;
            endcase
          end
        end
        ST_TICK: begin
          if (en_r[cnt_r]) begin
            en_r[cnt_r] <= step.keep_en;
            if (step.hit) exp_r[cnt_r] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // channel counts; disarm leaves them, a disabled channel's count is never used
  always_ff @(posedge clk) begin
    if (accept && in_mode == MODE_ARM && idx_ok) begin
      rem_r[wr_idx]    <= in_ivl;
      reload_r[wr_idx] <= in_ivl;
    end else if (state_r == ST_TICK && en_r[cnt_r]) begin
      rem_r[cnt_r] <= step.remaining;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {{(OUT_DATA_W - 3){1'b0}}, oidx_r};
  assign out_tuser  = ofired_r;
  assign out_tlast  = olast_r;

endmodule
